[hw/rtl/point_in_polygon_radius_test_macros.svh]
// Assertion macros used by the checker of the polygon test block.
`ifndef POINT_IN_POLYGON_RADIUS_TEST_MACROS_SVH
`define POINT_IN_POLYGON_RADIUS_TEST_MACROS_SVH

// Checked on every clock edge outside of reset.
`define PIP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define PIP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/pip_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

  localparam int MAX_VERTS  = 64;
  localparam int COORD_BITS = 32;
  localparam int AW         = $clog2(MAX_VERTS);
  localparam int CW         = $clog2(MAX_VERTS + 1);
  // Width of the serial multiplier operands; the product is twice as wide.
  localparam int SW         = 66;

  localparam logic signed [31:0] BOX_POS = 32'sh7fff_ffff;
  localparam logic signed [31:0] BOX_NEG = 32'sh8000_0000;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_QUERY  = 2'd2
  } mode_e;

  // Keep the low COORD_BITS bits of a coordinate and sign-extend them.
  function automatic logic signed [31:0] coord_ext(input logic [31:0] v);
    return 32'(signed'(v[COORD_BITS-1:0]));
  endfunction

endpackage

`default_nettype wire

[hw/rtl/pip_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Input channel: one word is a command with its point and radius.
interface pip_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic [30:0]        radius;

  modport source(output valid, mode, point_x, point_y, radius, input ready);
  modport sink(input valid, mode, point_x, point_y, radius, output ready);
endinterface

// Output channel: one word per accepted input word.
interface pip_out_if;
  logic valid;
  logic ready;
  logic status;
  logic inside_res;
  logic near_edge;

  modport source(output valid, status, inside_res, near_edge, input ready);
  modport sink(input valid, status, inside_res, near_edge, output ready);
endinterface

`default_nettype wire

[hw/rtl/pip_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM with a registered read.
module pip_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pip_smul.sv]
`timescale 1ns / 1ps
`default_nettype none

// Unsigned shift-and-add multiplier, two multiplier bits per cycle.
// It finishes as soon as the remaining multiplier bits are all zero.
module pip_smul import pip_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [SW-1:0]       a_i,
  input  wire logic [SW-1:0]       b_i,
  output logic                     done_o,
  output logic      [2*SW-1:0]     prod_o
);

  logic            busy_q;
  logic [2*SW-1:0] m1_q, m3_q, acc_q, addend;
  logic [SW-1:0]   b_q;

  // Pick the multiple of the multiplicand for the next two bits.
  always_comb begin
    case (b_q[1:0])
      2'd0:    addend = '0;
      2'd1:    addend = m1_q;
      2'd2:    addend = m1_q << 1;
      2'd3:    addend = m3_q;
      default: addend = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      m1_q   <= '0;
      m3_q   <= '0;
      acc_q  <= '0;
      b_q    <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      m1_q   <= (2*SW)'(a_i);
      m3_q   <= (2*SW)'(a_i) + ((2*SW)'(a_i) << 1);
      acc_q  <= '0;
      b_q    <= b_i;
    end else if (busy_q) begin
      if (b_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        acc_q <= acc_q + addend;
        m1_q  <= m1_q << 2;
        m3_q  <= m3_q << 2;
        b_q   <= b_q >> 2;
      end
    end
  end

  assign done_o = busy_q && (b_q == '0);
  assign prod_o = acc_q;

endmodule

`default_nettype wire

[hw/rtl/point_in_polygon_radius_test.sv]
`timescale 1ns / 1ps
`default_nettype none

// Clear, append and unused codes: the word goes through the result state into the output register,
// which waits while the output register is still full; the block then takes the next word.
// Query: a radius walk over the edges (two serial 66-bit products on an edge beside the
// point), skipped for a zero radius or an empty polygon; then the box check, the crossing walk
// over the edges if the point lies in the box, and the load of the result. One word at a time.
// Asynchronous active-low reset empties the polygon and the box; RAM contents are kept.
module point_in_polygon_radius_test import pip_pkg::*; (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  pip_in_if.sink    in_i,
  pip_out_if.source out_o
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_R2, ST_R2W, ST_RDJ, ST_LDJ, ST_LDI,
    ST_NDIFF, ST_NL0, ST_NL1, ST_ND0, ST_ND1, ST_NDOT, ST_NBR,
    ST_NW0, ST_NW1, ST_NV0, ST_NV1, ST_NSUM,
    ST_NC0, ST_NC1, ST_NCS, ST_NCM1, ST_NCM2,
    ST_NEXT, ST_BOX, ST_XDIFF, ST_XM0, ST_XM1, ST_XCMP, ST_RES
  } state_e;

  state_e             state_q;
  logic [CW-1:0]      count_q, idx_q, idx_nx;
  logic signed [31:0] min_x_q, min_y_q, max_x_q, max_y_q;
  logic signed [31:0] px_q, py_q, vjx_q, vjy_q, vix_q, viy_q;
  logic signed [31:0] in_x, in_y, rd_x, rd_y;
  logic [30:0]        rad_q;
  logic [SW-1:0]      r2_q, cross_q;
  logic signed [32:0] ex_q, ey_q, wx_q, wy_q, vx_q, vy_q;
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_q, acc_q;
  logic signed [66:0] l2_q, dot_q, sum67, dif67;
  logic [2*SW-1:0]    big_q, sm_prod;
  logic [SW-1:0]      sm_a, sm_b;
  logic               sm_start, sm_done;
  logic               pass_q, near_q, odd_q, straddle;
  logic               res_status_q, res_inside_q, res_near_q;
  logic               out_valid_q, out_status_q, out_inside_q, out_near_q;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_raddr;
  logic [63:0]        ram_rdata;

  assign in_x     = coord_ext(in_i.point_x);
  assign in_y     = coord_ext(in_i.point_y);
  assign rd_x     = signed'(ram_rdata[63:32]);
  assign rd_y     = signed'(ram_rdata[31:0]);
  assign idx_nx   = idx_q + CW'(1);
  assign sum67    = 67'(acc_q) + 67'(prod_q);
  assign dif67    = 67'(acc_q) - 67'(prod_q);
  assign straddle = (viy_q > py_q) != (vjy_q > py_q);

  // Vertex store: x in the upper half of the word, y in the lower half.
  assign ram_we = in_i.valid && (state_q == ST_IDLE) &&
                  (mode_e'(in_i.mode) == MODE_APPEND) && (count_q != CW'(MAX_VERTS));

  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = idx_q[AW-1:0];
    case (state_q)
      ST_RDJ: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(count_q - CW'(1));
      end
      ST_LDJ: begin
        ram_re = 1'b1;
      end
      ST_NEXT: begin
        ram_re    = 1'b1;
        ram_raddr = idx_nx[AW-1:0];
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  pip_ram #(
    .WIDTH(64),
    .DEPTH(MAX_VERTS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q[AW-1:0]),
    .wdata_i({in_x, in_y}),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Operand selection for the shared 33x33 product, one product per cycle.
  always_comb begin
    case (state_q)
      ST_R2:   begin mul_a = 33'(rad_q); mul_b = 33'(rad_q); end
      ST_NL0:  begin mul_a = ex_q;       mul_b = ex_q;       end
      ST_NL1:  begin mul_a = ey_q;       mul_b = ey_q;       end
      ST_ND0:  begin mul_a = wx_q;       mul_b = ex_q;       end
      ST_ND1:  begin mul_a = wy_q;       mul_b = ey_q;       end
      ST_NW0:  begin mul_a = wx_q;       mul_b = wx_q;       end
      ST_NW1:  begin mul_a = wy_q;       mul_b = wy_q;       end
      ST_NV0:  begin mul_a = vx_q;       mul_b = vx_q;       end
      ST_NV1:  begin mul_a = vy_q;       mul_b = vy_q;       end
      ST_NC0:  begin mul_a = wx_q;       mul_b = ey_q;       end
      ST_NC1:  begin mul_a = wy_q;       mul_b = ex_q;       end
      ST_XM0:  begin mul_a = wx_q;       mul_b = ey_q;       end
      ST_XM1:  begin mul_a = ex_q;       mul_b = wy_q;       end
      default: begin mul_a = '0;         mul_b = '0;         end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // Wide products: radius squared times edge length squared, then cross squared.
  assign sm_start = (state_q == ST_NCS) || ((state_q == ST_NCM1) && sm_done);
  assign sm_a     = (state_q == ST_NCS) ? r2_q : cross_q;
  assign sm_b     = (state_q == ST_NCS) ? l2_q[SW-1:0] : cross_q;

  pip_smul u_smul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(sm_start),
    .a_i    (sm_a),
    .b_i    (sm_b),
    .done_o (sm_done),
    .prod_o (sm_prod)
  );

  // Sequencer and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      idx_q        <= '0;
      min_x_q      <= BOX_POS;
      min_y_q      <= BOX_POS;
      max_x_q      <= BOX_NEG;
      max_y_q      <= BOX_NEG;
      px_q         <= '0;
      py_q         <= '0;
      vjx_q        <= '0;
      vjy_q        <= '0;
      vix_q        <= '0;
      viy_q        <= '0;
      rad_q        <= '0;
      r2_q         <= '0;
      cross_q      <= '0;
      big_q        <= '0;
      ex_q         <= '0;
      ey_q         <= '0;
      wx_q         <= '0;
      wy_q         <= '0;
      vx_q         <= '0;
      vy_q         <= '0;
      acc_q        <= '0;
      l2_q         <= '0;
      dot_q        <= '0;
      pass_q       <= 1'b0;
      near_q       <= 1'b0;
      odd_q        <= 1'b0;
      res_status_q <= 1'b0;
      res_inside_q <= 1'b0;
      res_near_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      out_status_q <= 1'b0;
      out_inside_q <= 1'b0;
      out_near_q   <= 1'b0;
    end else begin
      // The result state reloads the output register itself.
      if (out_valid_q && out_o.ready && (state_q != ST_RES)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        // Take a word; clear and append finish here.
        ST_IDLE: begin
          if (in_i.valid) begin
            res_status_q <= 1'b0;
            res_inside_q <= 1'b0;
            res_near_q   <= 1'b0;
            state_q      <= ST_RES;
            case (mode_e'(in_i.mode))
              MODE_CLEAR: begin
                count_q <= '0;
                min_x_q <= BOX_POS;
                min_y_q <= BOX_POS;
                max_x_q <= BOX_NEG;
                max_y_q <= BOX_NEG;
              end
              MODE_APPEND: begin
                if (count_q == CW'(MAX_VERTS)) begin
                  res_status_q <= 1'b1;
                end else begin
                  count_q <= count_q + CW'(1);
                  if (in_x < min_x_q) min_x_q <= in_x;
                  if (in_x > max_x_q) max_x_q <= in_x;
                  if (in_y < min_y_q) min_y_q <= in_y;
                  if (in_y > max_y_q) max_y_q <= in_y;
                end
              end
              MODE_QUERY: begin
                px_q   <= in_x;
                py_q   <= in_y;
                rad_q  <= in_i.radius;
                near_q <= 1'b0;
                pass_q <= 1'b0;
                if ((in_i.radius != '0) && (count_q != '0)) begin
                  state_q <= ST_R2;
                end else begin
                  state_q <= ST_BOX;
                end
              end
              default: begin
                state_q <= ST_RES;
              end
            endcase
          end
        end
        ST_R2: begin
          state_q <= ST_R2W;
        end
        ST_R2W: begin
          r2_q    <= SW'(prod_q);
          state_q <= ST_RDJ;
        end
        // Edge walk: the closing vertex first, then vertices 0 to n-1.
        ST_RDJ: begin
          idx_q   <= '0;
          state_q <= ST_LDJ;
        end
        ST_LDJ: begin
          vjx_q   <= rd_x;
          vjy_q   <= rd_y;
          state_q <= ST_LDI;
        end
        ST_LDI: begin
          vix_q   <= rd_x;
          viy_q   <= rd_y;
          state_q <= pass_q ? ST_XDIFF : ST_NDIFF;
        end
        // Segment from vertex j to vertex i against the query point.
        ST_NDIFF: begin
          ex_q    <= 33'(vix_q) - 33'(vjx_q);
          ey_q    <= 33'(viy_q) - 33'(vjy_q);
          wx_q    <= 33'(px_q) - 33'(vjx_q);
          wy_q    <= 33'(py_q) - 33'(vjy_q);
          vx_q    <= 33'(px_q) - 33'(vix_q);
          vy_q    <= 33'(py_q) - 33'(viy_q);
          state_q <= ST_NL0;
        end
        ST_NL0: begin
          // A zero-length edge is a single point.
          state_q <= ((ex_q == '0) && (ey_q == '0)) ? ST_NW0 : ST_NL1;
        end
        ST_NL1: begin
          acc_q   <= prod_q;
          state_q <= ST_ND0;
        end
        ST_ND0: begin
          l2_q    <= sum67;
          state_q <= ST_ND1;
        end
        ST_ND1: begin
          acc_q   <= prod_q;
          state_q <= ST_NDOT;
        end
        ST_NDOT: begin
          dot_q   <= sum67;
          state_q <= ST_NBR;
        end
        // Before the start, past the end, or beside the segment.
        ST_NBR: begin
          if (dot_q < 67'sd0) begin
            state_q <= ST_NW0;
          end else if (dot_q > l2_q) begin
            state_q <= ST_NV0;
          end else begin
            state_q <= ST_NC0;
          end
        end
        ST_NW0: begin
          state_q <= ST_NW1;
        end
        ST_NW1: begin
          acc_q   <= prod_q;
          state_q <= ST_NSUM;
        end
        ST_NV0: begin
          state_q <= ST_NV1;
        end
        ST_NV1: begin
          acc_q   <= prod_q;
          state_q <= ST_NSUM;
        end
        ST_NSUM: begin
          near_q  <= sum67 < 67'(r2_q);
          state_q <= ST_NEXT;
        end
        ST_NC0: begin
          state_q <= ST_NC1;
        end
        ST_NC1: begin
          acc_q   <= prod_q;
          state_q <= ST_NCS;
        end
        ST_NCS: begin
          cross_q <= dif67[66] ? SW'(-dif67) : SW'(dif67);
          state_q <= ST_NCM1;
        end
        ST_NCM1: begin
          if (sm_done) begin
            big_q   <= sm_prod;
            state_q <= ST_NCM2;
          end
        end
        ST_NCM2: begin
          if (sm_done) begin
            near_q  <= sm_prod < big_q;
            state_q <= ST_NEXT;
          end
        end
        // Advance to the next edge or close the walk.
        ST_NEXT: begin
          if (!pass_q && near_q) begin
            res_inside_q <= 1'b1;
            res_near_q   <= 1'b1;
            state_q      <= ST_RES;
          end else if (idx_nx == count_q) begin
            if (pass_q) begin
              res_inside_q <= odd_q;
              state_q      <= ST_RES;
            end else begin
              state_q <= ST_BOX;
            end
          end else begin
            idx_q   <= idx_nx;
            vjx_q   <= vix_q;
            vjy_q   <= viy_q;
            state_q <= ST_LDI;
          end
        end
        ST_BOX: begin
          if ((px_q < min_x_q) || (py_q < min_y_q) || (px_q > max_x_q) ||
              (py_q > max_y_q)) begin
            state_q <= ST_RES;
          end else begin
            pass_q  <= 1'b1;
            odd_q   <= 1'b0;
            state_q <= ST_RDJ;
          end
        end
        // Crossing test for the edge from vertex i to vertex j.
        ST_XDIFF: begin
          wx_q    <= 33'(px_q) - 33'(vix_q);
          ey_q    <= 33'(vjy_q) - 33'(viy_q);
          ex_q    <= 33'(vjx_q) - 33'(vix_q);
          wy_q    <= 33'(py_q) - 33'(viy_q);
          state_q <= straddle ? ST_XM0 : ST_NEXT;
        end
        ST_XM0: begin
          state_q <= ST_XM1;
        end
        ST_XM1: begin
          acc_q   <= prod_q;
          state_q <= ST_XCMP;
        end
        ST_XCMP: begin
          if (!ey_q[32] ? (acc_q < prod_q) : (acc_q > prod_q)) begin
            odd_q <= !odd_q;
          end
          state_q <= ST_NEXT;
        end
        // Hand the result to the output register once it is free.
        ST_RES: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q  <= 1'b1;
            out_status_q <= res_status_q;
            out_inside_q <= res_inside_q;
            out_near_q   <= res_near_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.inside_res = out_inside_q;
  assign out_o.near_edge  = out_near_q;

endmodule

`default_nettype wire

[hw/rtl/pip_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "point_in_polygon_radius_test_macros.svh"

// Port-level checks of the polygon test block.
module pip_chk (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i,
  input wire logic out_status_i,
  input wire logic out_inside_res_i,
  input wire logic out_near_edge_i
);

  // A waiting result word keeps its value.
  `PIP_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i) && $stable(out_inside_res_i) && $stable(out_near_edge_i), "result word changed while stalled")

  // One word is in work at a time.
  `PIP_ASSERT(a_one_item, clk_i, rst_ni, in_valid_i && in_ready_i |=> !in_ready_i, "input taken while a word is in work")

  // A radius hit always counts as inside.
  `PIP_ASSERT_ALWAYS(a_near_inside, clk_i, out_valid_i && out_near_edge_i |-> out_inside_res_i, "near hit without inside flag")

  // A refused append carries no query flags.
  `PIP_ASSERT(a_full_flags, clk_i, rst_ni, out_valid_i && out_status_i |-> !out_inside_res_i && !out_near_edge_i, "query flags on a refused append")

endmodule

bind point_in_polygon_radius_test pip_chk u_pip_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_i.valid),
  .in_ready_i      (in_i.ready),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .out_status_i    (out_o.status),
  .out_inside_res_i(out_o.inside_res),
  .out_near_edge_i (out_o.near_edge)
);

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import pip_pkg::*;

  localparam int  CLK_PERIOD = 12;
  localparam int  RESET_CYCLES = 12;
  localparam int  RANDOM_ITEMS = 900;
  localparam int  QUIET_ITEMS = 120;
  localparam longint CYCLE_LIMIT = 64'd20_000_000;

  // Wide enough for every exact product the crossing and distance tests form.
  typedef logic signed [191:0] wide_t;

  typedef struct packed {
    logic status;
    logic inside_res;
    logic near_edge;
  } verdict_t;

  logic clk_i;
  logic rst_ni;

  pip_in_if  in_if ();
  pip_out_if out_if ();

  point_in_polygon_radius_test u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Shadow copy of the polygon held by the block.
  int     shadow_x [MAX_VERTS];
  int     shadow_y [MAX_VERTS];
  int     shadow_count;
  int     box_lo_x, box_lo_y, box_hi_x, box_hi_y;

  verdict_t awaited_verdicts[$];
  int       error_count;
  int       words_sent;
  bit       quiet;
  longint   cycle_count;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Run limit.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic int coord_of(input logic [31:0] v);
    return int'($signed(v << (32 - COORD_BITS)) >>> (32 - COORD_BITS));
  endfunction

  function automatic void empty_polygon();
    shadow_count = 0;
    box_lo_x = BOX_POS;
    box_lo_y = BOX_POS;
    box_hi_x = BOX_NEG;
    box_hi_y = BOX_NEG;
  endfunction

  function automatic wide_t sq_sum(input wide_t a, input wide_t b);
    return a * a + b * b;
  endfunction

  // Clamped segment distance test: true when the point lies closer than the radius.
  function automatic bit segment_close(input longint ax, input longint ay, input longint bx,
                                       input longint by, input longint px, input longint py,
                                       input wide_t r2);
    wide_t ex, ey, wx, wy, l2, dot, cr;
    ex = wide_t'(bx - ax);
    ey = wide_t'(by - ay);
    wx = wide_t'(px - ax);
    wy = wide_t'(py - ay);
    if (ex == 0 && ey == 0) return sq_sum(wx, wy) < r2;
    l2  = sq_sum(ex, ey);
    dot = wx * ex + wy * ey;
    if (dot < 0) return sq_sum(wx, wy) < r2;
    if (dot > l2) return sq_sum(wide_t'(px - bx), wide_t'(py - by)) < r2;
    cr = wx * ey - wy * ex;
    return cr * cr < r2 * l2;
  endfunction

  // Even-odd crossing test behind the bounding box check.
  function automatic bit crossing_odd(input longint px, input longint py);
    bit     odd;
    int     j;
    longint xi, yi, xj, yj, dy;
    wide_t  lhs, rhs;
    odd = 1'b0;
    if (px < box_lo_x || py < box_lo_y || px > box_hi_x || py > box_hi_y) return 1'b0;
    j = shadow_count - 1;
    for (int i = 0; i < shadow_count; i++) begin
      xi = shadow_x[i];
      yi = shadow_y[i];
      xj = shadow_x[j];
      yj = shadow_y[j];
      if ((yi > py) != (yj > py)) begin
        dy  = yj - yi;
        lhs = wide_t'(px - xi) * wide_t'(dy);
        rhs = wide_t'(xj - xi) * wide_t'(py - yi);
        if (dy > 0 ? lhs < rhs : lhs > rhs) odd = ~odd;
      end
      j = i;
    end
    return odd;
  endfunction

  // Apply one word to the shadow polygon and return the verdict it produces.
  function automatic verdict_t classify_word(input logic [1:0] mode, input logic [31:0] x,
                                             input logic [31:0] y, input logic [30:0] r);
    verdict_t v;
    longint   px, py;
    wide_t    r2;
    bit       close;
    int       j;
    v  = '0;
    px = coord_of(x);
    py = coord_of(y);
    case (mode)
      MODE_CLEAR: begin
        empty_polygon();
      end
      MODE_APPEND: begin
        if (shadow_count >= MAX_VERTS) begin
          v.status = 1'b1;
        end else begin
          shadow_x[shadow_count] = int'(px);
          shadow_y[shadow_count] = int'(py);
          shadow_count++;
          if (px < box_lo_x) box_lo_x = int'(px);
          if (px > box_hi_x) box_hi_x = int'(px);
          if (py < box_lo_y) box_lo_y = int'(py);
          if (py > box_hi_y) box_hi_y = int'(py);
        end
      end
      MODE_QUERY: begin
        close = 1'b0;
        if (r != 0) begin
          r2 = wide_t'({1'b0, r}) * wide_t'({1'b0, r});
          j = shadow_count - 1;
          for (int i = 0; i < shadow_count && !close; i++) begin
            close = segment_close(shadow_x[j], shadow_y[j], shadow_x[i], shadow_y[i],
                                  px, py, r2);
            j = i;
          end
        end
        if (close) begin
          v.inside_res = 1'b1;
          v.near_edge  = 1'b1;
        end else begin
          v.inside_res = crossing_odd(px, py);
        end
      end
      default: begin
      end
    endcase
    return v;
  endfunction

  // Send one word, now and then with a random gap ahead of it unless the run is quiet.
  task automatic send_word(input logic [1:0] mode, input logic [31:0] x, input logic [31:0] y,
                           input logic [30:0] r);
    int gap;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid   <= 1'b1;
    in_if.mode    <= mode;
    in_if.point_x <= x;
    in_if.point_y <= y;
    in_if.radius  <= r;
    do @(posedge clk_i); while (!in_if.ready);
    awaited_verdicts = {awaited_verdicts, classify_word(mode, x, y, r)};
    words_sent++;
  endtask

  task automatic finish_sending();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
  endtask

  // Result receiver: stalls come in bursts.
  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (quiet || $urandom_range(0, 2) != 0) begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 30)) begin
          @(negedge clk_i);
          if (quiet) out_if.ready <= 1'b1;
        end
      end else begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12) - 1) @(negedge clk_i);
      end
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (awaited_verdicts.size() == 0) begin
        $display("%0t unexpected result word: status %0d inside %0d near %0d", $time,
                 out_if.status, out_if.inside_res, out_if.near_edge);
        error_count++;
      end else begin
        want = awaited_verdicts.pop_front();
        if (out_if.status !== want.status) begin
          $display("%0t status mismatch: expected %0d actual %0d", $time, want.status,
                   out_if.status);
          error_count++;
        end
        if (out_if.inside_res !== want.inside_res) begin
          $display("%0t inside_res mismatch: expected %0d actual %0d", $time,
                   want.inside_res, out_if.inside_res);
          error_count++;
        end
        if (out_if.near_edge !== want.near_edge) begin
          $display("%0t near_edge mismatch: expected %0d actual %0d", $time,
                   want.near_edge, out_if.near_edge);
          error_count++;
        end
      end
    end
  end

  // Empty polygon, the unused code, and a single vertex seen as a point.
  task automatic test_empty_and_single();
    send_word(MODE_QUERY, 32'h0, 32'h0, 31'h0);
    send_word(MODE_QUERY, 32'h0, 32'h0, 31'h7fff_ffff);
    send_word(2'd3, 32'hffff_ffff, 32'hffff_ffff, 31'h7fff_ffff);
    send_word(MODE_APPEND, 32'h0001_0000, 32'h0001_0000, 31'h0);
    send_word(MODE_QUERY, 32'h0001_0000, 32'h0001_0000, 31'h0);
    send_word(MODE_QUERY, 32'h0001_8000, 32'h0001_0000, 31'h0000_8001);
    send_word(MODE_QUERY, 32'h0001_8000, 32'h0001_0000, 31'h0000_8000);
    send_word(MODE_CLEAR, 32'h0, 32'h0, 31'h0);
  endtask

  // Full-range square with a repeated vertex; border, edge and corner points.
  task automatic test_extreme_square();
    send_word(MODE_APPEND, 32'h8000_0000, 32'h8000_0000, 31'h0);
    send_word(MODE_APPEND, 32'h7fff_ffff, 32'h8000_0000, 31'h0);
    send_word(MODE_APPEND, 32'h7fff_ffff, 32'h8000_0000, 31'h0);
    send_word(MODE_APPEND, 32'h7fff_ffff, 32'h7fff_ffff, 31'h0);
    send_word(MODE_APPEND, 32'h8000_0000, 32'h7fff_ffff, 31'h0);
    send_word(MODE_QUERY, 32'h0, 32'h0, 31'h0);
    send_word(MODE_QUERY, 32'h8000_0000, 32'h0, 31'h0);
    send_word(MODE_QUERY, 32'h7fff_ffff, 32'h0, 31'h0);
    send_word(MODE_QUERY, 32'h0, 32'h8000_0000, 31'h0);
    send_word(MODE_QUERY, 32'h0, 32'h7fff_ffff, 31'h0);
    send_word(MODE_QUERY, 32'h7fff_ffff, 32'h7fff_ffff, 31'h1);
    send_word(MODE_QUERY, 32'h0, 32'h0, 31'h7fff_ffff);
    send_word(MODE_QUERY, 32'h8000_0000, 32'h8000_0000, 31'h7fff_ffff);
    send_word(MODE_CLEAR, 32'h0, 32'h0, 31'h0);
  endtask

  // Fill the store, refuse two more vertices, and query the largest polygon.
  task automatic test_full_store();
    int ang;
    for (int i = 0; i < MAX_VERTS + 2; i++) begin
      ang = i % MAX_VERTS;
      send_word(MODE_APPEND, 32'(ang < 32 ? ang * 32'h1_0000 : (64 - ang) * 32'h1_0000),
                32'(ang < 32 ? ang * ang * 32'h1000 : -(64 - ang) * (64 - ang) * 32'h1000),
                31'h0);
    end
    send_word(MODE_QUERY, 32'h0008_0000, 32'h0, 31'h0);
    send_word(MODE_QUERY, 32'h0008_0000, 32'h0, 31'h0002_0000);
    send_word(MODE_CLEAR, 32'h0, 32'h0, 31'h0);
  endtask

  function automatic logic [31:0] near_value(input int base, input int spread);
    return 32'(base + $signed($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // Random polygons, mostly well formed, each queried several times.
  task automatic test_random_polygons();
    int n_verts, spread, base_x, base_y, n_queries, pick;
    logic [31:0] qx, qy;
    logic [30:0] rad;
    while (words_sent < RANDOM_ITEMS) begin
      if (words_sent > RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      case ($urandom_range(0, 3))
        0:       spread = 32'h100;
        1:       spread = 32'h1_0000;
        2:       spread = 32'h100_0000;
        default: spread = 32'h3fff_ffff;
      endcase
      base_x = (spread == 32'h3fff_ffff) ? 0 : $signed($urandom) >>> 2;
      base_y = (spread == 32'h3fff_ffff) ? 0 : $signed($urandom) >>> 2;
      pick = $urandom_range(0, 39);
      if (pick == 0) n_verts = MAX_VERTS + 1;
      else if (pick < 4) n_verts = $urandom_range(1, 2);
      else n_verts = $urandom_range(3, 8);
      if ($urandom_range(0, 7) != 0) send_word(MODE_CLEAR, $urandom, $urandom, 31'($urandom));
      for (int i = 0; i < n_verts; i++) begin
        if (spread == 32'h3fff_ffff) send_word(MODE_APPEND, $urandom, $urandom, 31'($urandom));
        else send_word(MODE_APPEND, near_value(base_x, spread), near_value(base_y, spread),
                       31'($urandom));
      end
      n_queries = (n_verts > 8) ? 2 : $urandom_range(2, 8);
      for (int q = 0; q < n_queries; q++) begin
        if (spread == 32'h3fff_ffff) begin
          qx = $urandom;
          qy = $urandom;
        end else begin
          qx = near_value(base_x, spread);
          qy = near_value(base_y, spread);
        end
        case ($urandom_range(0, 4))
          0, 1:    rad = '0;
          2:       rad = 31'($urandom_range(1, spread / 4 + 1));
          3:       rad = 31'($urandom_range(1, spread + 1));
          default: rad = 31'($urandom);
        endcase
        send_word(MODE_QUERY, qx, qy, rad);
        if ($urandom_range(0, 29) == 0) send_word(2'd3, $urandom, $urandom, 31'($urandom));
      end
    end
  endtask

  // Stimulus, then drain and report.
  initial begin
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.mode    = MODE_CLEAR;
    in_if.point_x = '0;
    in_if.point_y = '0;
    in_if.radius  = '0;
    error_count   = 0;
    words_sent    = 0;
    quiet         = 1'b0;
    empty_polygon();
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_and_single();
    test_extreme_square();
    test_full_store();
    test_random_polygons();
    finish_sending();

    while (awaited_verdicts.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (error_count == 0 && awaited_verdicts.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[point_in_polygon_radius_test.f]
+incdir+hw/rtl
hw/rtl/pip_pkg.sv
hw/rtl/pip_if.sv
hw/rtl/pip_ram.sv
hw/rtl/pip_smul.sv
hw/rtl/point_in_polygon_radius_test.sv
hw/rtl/pip_chk.sv
tb/testbench.sv
